FILE: sv/mau_pkg.sv
`default_nettype none
package mau_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RED,
        BK_EUC,
        BK_MUL,
        BK_MRED,
        BK_DONE
    } bk_state_t;

    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;
endpackage
`default_nettype wire

FILE: sv/modular_arith_unit.sv
// The back end reduces both operands modulo m; for divide it then runs extended
// Euclid iterations to invert b, and multiply and divide reduce a product at the end.
// Back end runs one item at a time and takes no new item until it is idle;
// the front register and a one-entry queue hold up to two more items.
// Reset: asynchronous active low, modulus returns to 1000000007.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module modular_arith_unit
    import mau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 64,
    parameter int MODULUS_WIDTH = 31
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [30:0]              cfg_data,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               mode,
    input  wire logic [OPERAND_WIDTH-1:0] operand_a,
    input  wire logic [OPERAND_WIDTH-1:0] operand_b,
    output logic                          result_valid,
    output logic [30:0]                   residue,
    output logic                          no_inverse
);
    logic [MODULUS_WIDTH-1:0] mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MODULUS_RESET[MODULUS_WIDTH-1:0];
        else if (cfg_we)
            mod_reg <= cfg_data[MODULUS_WIDTH-1:0];
    end

    logic q_push, q_pop, q_valid_reg, bk_idle;
    logic [1:0] f_mode, q_mode_reg;
    logic [OPERAND_WIDTH-1:0] f_a, f_b, q_a_reg, q_b_reg;
    logic [MODULUS_WIDTH-1:0] res_w;

    mau_front #(.OW(OPERAND_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .mode(mode),
        .operand_a(operand_a), .operand_b(operand_b),
        .q_full(q_valid_reg && !q_pop), .q_push(q_push),
        .q_mode(f_mode), .q_a(f_a), .q_b(f_b), .busy(busy)
    );

    // one-entry queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (q_push)
            q_valid_reg <= 1'b1;
        else if (q_pop)
            q_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mode_reg <= f_mode;
            q_a_reg    <= f_a;
            q_b_reg    <= f_b;
        end
    end

    mau_back #(.OW(OPERAND_WIDTH), .MW(MODULUS_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .m(mod_reg),
        .q_valid(q_valid_reg), .q_mode(q_mode_reg), .q_a(q_a_reg), .q_b(q_b_reg),
        .q_pop(q_pop), .done(result_valid), .residue(res_w),
        .no_inverse(no_inverse), .idle(bk_idle)
    );

    assign residue = 31'(res_w);

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid_reg) else $error("pop of empty queue");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> bk_idle) else $error("back not idle after result");
    a_flag_div: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_inverse |-> residue == 31'd0) else $error("flag with residue");
endmodule
`default_nettype wire

FILE: sv/mau_front.sv
`default_nettype none
module mau_front
    import mau_pkg::*;
#(
    parameter int OW = 64
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    mode,
    input  wire logic [OW-1:0] operand_a,
    input  wire logic [OW-1:0] operand_b,
    input  wire logic          q_full,
    output logic               q_push,
    output logic [1:0]         q_mode,
    output logic [OW-1:0]      q_a,
    output logic [OW-1:0]      q_b,
    output logic               busy
);
    // single-entry holding register in front of the queue
    logic          hold_reg;
    logic [1:0]    mode_reg;
    logic [OW-1:0] a_reg, b_reg;

    assign busy   = hold_reg;
    assign q_push = hold_reg && !q_full;
    assign q_mode = mode_reg;
    assign q_a    = a_reg;
    assign q_b    = b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (start && !hold_reg)
        begin
            hold_reg <= 1'b1;
        end
        else if (q_push)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !hold_reg)
        begin
            mode_reg <= mode;
            a_reg    <= operand_a;
            b_reg    <= operand_b;
        end
    end
endmodule
`default_nettype wire

FILE: sv/mau_back.sv
`default_nettype none
module mau_back
    import mau_pkg::*;
#(
    parameter int OW = 64,
    parameter int MW = 31
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [MW-1:0] m,
    input  wire logic          q_valid,
    input  wire logic [1:0]    q_mode,
    input  wire logic [OW-1:0] q_a,
    input  wire logic [OW-1:0] q_b,
    output logic               q_pop,
    output logic               done,
    output logic [MW-1:0]      residue,
    output logic               no_inverse,
    output logic               idle
);
    localparam int PW = 2 * MW;
    localparam int CW = $clog2(OW + 1);
    localparam int QW = $clog2(MW + 1);

    bk_state_t state_reg, state_next;

    logic [1:0]    mode_reg;
    logic          nega_reg, negb_reg;
    logic [OW-1:0] ma_reg, mb_reg;         // magnitudes, shifted out msb first
    logic [MW:0]   ra_reg, rb_reg;         // partial remainders
    logic [CW-1:0] cnt_reg;
    // euclid: r0,r1 remainders; t0,t1 coefficients mod m
    logic [MW-1:0] r0_reg, r1_reg, t0_reg, t1_reg;
    logic [MW-1:0] x_reg, y_reg;           // multiplier operands
    logic [PW-1:0] p_reg;
    logic [MW:0]   pr_reg;                 // product reduction remainder
    logic [MW-1:0] res_reg;
    logic          flag_reg;
    // binary long division for euclid quotient step
    logic [MW-1:0] qd_rem_reg, qd_q_reg;
    logic [QW-1:0] qd_cnt_reg;
    logic          qd_busy_reg;
    logic [MW-1:0] qt_reg;                 // q*t1 mod m accumulator
    logic          qt_phase_reg;

    logic          m_ok;
    assign m_ok = (m >= MW'(2));

    assign idle = (state_reg == BK_IDLE);
    assign q_pop = (state_reg == BK_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_RED;
            BK_RED:  if (cnt_reg == CW'(OW)) state_next = (mode_reg == OP_DIV) ? BK_EUC : BK_MUL;
            BK_EUC:  if (!qd_busy_reg && !qt_phase_reg && r1_reg == '0) state_next = BK_MUL;
            BK_MUL:  state_next = BK_MRED;
            BK_MRED: if (cnt_reg == CW'(0)) state_next = BK_DONE;
            BK_DONE: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        done       = (state_reg == BK_DONE);
        residue    = res_reg;
        no_inverse = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    function automatic logic [MW:0] rstep(input logic [MW:0] r, input logic bit_in,
                                           input logic [MW-1:0] md);
        logic [MW+1:0] s;
        s = {r, bit_in};
        if (s >= {2'b0, md})
            s = s - {2'b0, md};
        return s[MW:0];
    endfunction

    function automatic logic [MW-1:0] fixneg(input logic neg, input logic [MW:0] r,
                                             input logic [MW-1:0] md);
        if (neg && r != '0)
            return md - r[MW-1:0];
        return r[MW-1:0];
    endfunction

    logic [MW-1:0] a_res, b_res;
    assign a_res = fixneg(nega_reg, ra_reg, m);
    assign b_res = fixneg(negb_reg, rb_reg, m);

    logic [MW:0] msum;
    logic [MW:0] qt_dbl;
    logic [MW:0] pr_next;

    assign msum    = {1'b0, a_res} + {1'b0, b_res};
    assign pr_next = rstep(pr_reg, p_reg[PW-1], m);

    // qt = q * t1 mod m, msb first double-and-add
    always_comb
    begin
        qt_dbl = {qt_reg, 1'b0};
        if (qt_dbl >= {1'b0, m}) qt_dbl = qt_dbl - {1'b0, m};
        if (qd_q_reg[MW-1])
        begin
            qt_dbl = qt_dbl + {1'b0, t1_reg};
            if (qt_dbl >= {1'b0, m}) qt_dbl = qt_dbl - {1'b0, m};
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    mode_reg <= q_mode;
                    nega_reg <= q_a[OW-1];
                    negb_reg <= q_b[OW-1];
                    ma_reg   <= q_a[OW-1] ? (~q_a + OW'(1)) : q_a;
                    mb_reg   <= q_b[OW-1] ? (~q_b + OW'(1)) : q_b;
                    ra_reg   <= '0;
                    rb_reg   <= '0;
                    cnt_reg  <= '0;
                end
            end
            BK_RED:
            begin
                if (cnt_reg != CW'(OW))
                begin
                    ra_reg  <= rstep(ra_reg, ma_reg[OW-1], m);
                    rb_reg  <= rstep(rb_reg, mb_reg[OW-1], m);
                    ma_reg  <= ma_reg << 1;
                    mb_reg  <= mb_reg << 1;
                    cnt_reg <= cnt_reg + CW'(1);
                end
                else
                begin
                    flag_reg     <= 1'b0;
                    r0_reg       <= m;
                    r1_reg       <= b_res;
                    t0_reg       <= '0;
                    t1_reg       <= MW'(1);
                    qd_busy_reg  <= 1'b0;
                    qt_phase_reg <= 1'b0;
                    case (mode_reg)
                        OP_ADD:
                        begin
                            y_reg <= '0;
                            x_reg <= (msum >= {1'b0, m}) ? MW'(msum - {1'b0, m}) : msum[MW-1:0];
                        end
                        OP_SUB:
                        begin
                            y_reg <= '0;
                            x_reg <= (a_res >= b_res) ? a_res - b_res : a_res + (m - b_res);
                        end
                        default:
                        begin
                            x_reg <= a_res;
                            y_reg <= b_res;
                        end
                    endcase
                end
            end
            BK_EUC:
            begin
                if (qd_busy_reg)
                begin
                    // restoring division r0 / r1, one quotient bit a cycle
                    if ({qd_rem_reg, r0_reg[MW-1]} >= {1'b0, r1_reg})
                    begin
                        qd_rem_reg <= MW'({qd_rem_reg, r0_reg[MW-1]} - {1'b0, r1_reg});
                        qd_q_reg   <= {qd_q_reg[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        qd_rem_reg <= {qd_rem_reg[MW-2:0], r0_reg[MW-1]};
                        qd_q_reg   <= {qd_q_reg[MW-2:0], 1'b0};
                    end
                    r0_reg <= r0_reg << 1;
                    if (qd_cnt_reg == QW'(1))
                    begin
                        qd_busy_reg  <= 1'b0;
                        qt_phase_reg <= 1'b1;
                        qt_reg       <= '0;
                        qd_cnt_reg   <= QW'(MW);
                    end
                    else
                        qd_cnt_reg <= qd_cnt_reg - QW'(1);
                end
                else if (qt_phase_reg)
                begin
                    qd_q_reg   <= qd_q_reg << 1;
                    qd_cnt_reg <= qd_cnt_reg - QW'(1);
                    if (qd_cnt_reg == QW'(1))
                    begin
                        qt_phase_reg <= 1'b0;
                        r0_reg <= r1_reg;
                        r1_reg <= qd_rem_reg;
                        t0_reg <= t1_reg;
                        t1_reg <= (t0_reg >= qt_dbl[MW-1:0]) ? t0_reg - qt_dbl[MW-1:0]
                                  : t0_reg + (m - qt_dbl[MW-1:0]);
                    end
                    else
                        qt_reg <= qt_dbl[MW-1:0];
                end
                else if (r1_reg != '0)
                begin
                    qd_busy_reg <= 1'b1;
                    qd_rem_reg  <= '0;
                    qd_q_reg    <= '0;
                    qd_cnt_reg  <= QW'(MW);
                end
                else
                begin
                    if (r0_reg == MW'(1))
                        y_reg <= t0_reg;
                    else
                    begin
                        y_reg    <= '0;
                        flag_reg <= 1'b1;
                    end
                end
            end
            BK_MUL:
            begin
                p_reg   <= PW'(x_reg) * PW'(y_reg);
                pr_reg  <= '0;
                cnt_reg <= CW'(PW);
                if (mode_reg == OP_ADD || mode_reg == OP_SUB)
                    y_reg <= MW'(1);
            end
            BK_MRED:
            begin
                if (cnt_reg != CW'(0))
                begin
                    if (mode_reg == OP_ADD || mode_reg == OP_SUB)
                        cnt_reg <= CW'(0);
                    else
                    begin
                        pr_reg  <= pr_next;
                        p_reg   <= p_reg << 1;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                if (!m_ok)
                begin
                    res_reg  <= '0;
                    flag_reg <= 1'b0;
                end
                else if (cnt_reg != CW'(0))
                begin
                    res_reg <= (mode_reg == OP_ADD || mode_reg == OP_SUB) ? x_reg
                               : pr_next[MW-1:0];
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import mau_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [30:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        result_valid;
    logic [30:0] residue;
    logic        no_inverse;

    typedef struct packed {
        logic [30:0] residue;
        logic        no_inverse;
    } mod_result_t;

    mod_result_t result_q[$];
    logic [30:0] modulus;
    int          mismatch_count;

    modular_arith_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .result_valid (result_valid),
        .residue      (residue),
        .no_inverse   (no_inverse)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] reduce_operand(logic [63:0] raw, logic [63:0] m);
        logic [63:0] r;
        if (raw[63])
        begin
            r = (64'd0 - raw) % m;
            return (r != 0) ? m - r : 64'd0;
        end
        return raw % m;
    endfunction

    // extended Euclid; returns 0 when no inverse exists
    function automatic bit find_inverse(logic [63:0] b, logic [63:0] m,
                                        output logic [63:0] inv);
        longint r0, r1, t0, t1, q, rn, tn;
        r0 = m; r1 = b; t0 = 0; t1 = 1;
        inv = 0;
        while (r1 != 0)
        begin
            q = r0 / r1;
            rn = r0 - q * r1;
            tn = t0 - q * t1;
            r0 = r1; r1 = rn;
            t0 = t1; t1 = tn;
        end
        if (r0 != 1)
            return 1'b0;
        if (t0 < 0)
            t0 += m;
        inv = 64'(t0) % m;
        return 1'b1;
    endfunction

    function automatic mod_result_t predict_result(op_t op, logic [63:0] a_raw,
                                                   logic [63:0] b_raw);
        mod_result_t res;
        logic [63:0] m, a, b, inv;
        res = '0;
        m = 64'(modulus);
        if (m < 2)
            return res;
        a = reduce_operand(a_raw, m);
        b = reduce_operand(b_raw, m);
        case (op)
            OP_ADD: res.residue = 31'((a + b) % m);
            OP_SUB: res.residue = 31'((a + m - b) % m);
            OP_MUL: res.residue = 31'((a * b) % m);
            default:
            begin
                if (find_inverse(b, m, inv))
                    res.residue = 31'((a * inv) % m);
                else
                    res.no_inverse = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic send_item(op_t op, logic [63:0] a, logic [63:0] b);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        result_q.push_back(predict_result(op, a, b));
        start     <= 1'b1;
        mode      <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_modulus(logic [30:0] value);
        start <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        modulus = value;
    endtask

    always @(posedge clk)
    begin
        mod_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (result_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: residue %0d no_inverse %0b",
                             residue, no_inverse);
            end
            else
            begin
                exp_r = result_q.pop_front();
                if (exp_r.residue !== residue || exp_r.no_inverse !== no_inverse)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp residue %0d no_inverse %0b, got %0d %0b",
                                 exp_r.residue, exp_r.no_inverse, residue, no_inverse);
                end
            end
        end
    end

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 20));
            1: v = -64'($urandom_range(1, 20));
            2: v = 64'(modulus) * $urandom_range(0, 3) + $urandom_range(0, 2);
            3: v = {1'b1, 63'd0} | 64'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [63:0] ext[6];
        ext = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                64'h7FFF_FFFF_FFFF_FFFF, 64'd1000000006};
        for (int i = 0; i < 6; i++)
            send_item(op_t'(i % 4), ext[i], ext[5 - i]);
        send_item(OP_DIV, 64'd5, 64'd0);
        send_item(OP_DIV, 64'd7, 64'd1000000007);
        send_item(OP_DIV, 64'hFFFF_FFFF_FFFF_FFF0, 64'd3);
        send_item(OP_SUB, 64'd0, 64'd1);
    endtask

    task automatic test_composite_modulus();
        set_modulus(31'd12);
        for (int i = 0; i < 12; i++)
            send_item(OP_DIV, 64'($urandom), 64'(i));
        send_item(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_extreme_moduli();
        set_modulus(31'd2);
        for (int i = 0; i < 8; i++)
            send_item(op_t'(i % 4), rand_operand(), rand_operand());
        set_modulus(31'h7FFF_FFFF);
        for (int i = 0; i < 8; i++)
            send_item(op_t'(i % 4), rand_operand(), rand_operand());
        set_modulus(31'd1);
        for (int i = 0; i < 4; i++)
            send_item(op_t'(i), rand_operand(), rand_operand());
        set_modulus(31'd0);
        for (int i = 0; i < 4; i++)
            send_item(op_t'(i), rand_operand(), rand_operand());
    endtask

    task automatic test_random();
        logic [30:0] mods[5];
        mods = '{MODULUS_RESET, 31'd1000, 31'd65536, 31'h7FFF_FFFF, 31'd97};
        for (int p = 0; p < 5; p++)
        begin
            set_modulus(p == 2 ? 31'($urandom_range(2, 32'h7FFF_FFFF)) : mods[p]);
            for (int i = 0; i < 190; i++)
                send_item(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        mode = OP_ADD;
        operand_a = '0;
        operand_b = '0;
        modulus = MODULUS_RESET;
        mismatch_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_composite_modulus();
        test_extreme_moduli();
        test_random();
        start <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("modular_arith_unit regression: pass");
        else
            $display("modular_arith_unit regression: fail");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("modular_arith_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
sv/mau_pkg.sv
sv/mau_front.sv
sv/mau_back.sv
sv/modular_arith_unit.sv
dv/tb_top.sv
